// ===== src/point_rotate_about_axis_defines.svh =====
// Assertion macros shared by the point rotation block.
// Depends on nothing; included by the top level.
`ifndef POINT_ROTATE_ABOUT_AXIS_DEFINES_SVH
`define POINT_ROTATE_ABOUT_AXIS_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PROT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PROT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

// ===== src/prot_pkg.sv =====
// Shared types, codes and constants for the point rotation block.
// Depends on nothing.
`timescale 1ns / 1ps

package prot_pkg;

   typedef enum logic [2:0] {
      CSR_DIM_MODE   = 3'd0,
      CSR_AXIS_X     = 3'd1,
      CSR_AXIS_Y     = 3'd2,
      CSR_AXIS_Z     = 3'd3,
      CSR_TURN_ANGLE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FAULT_NONE        = 2'd0,
      FAULT_PLANAR_AXIS = 2'd1,
      FAULT_ZERO_AXIS   = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      SETUP_LOAD,
      SETUP_SQRT,
      SETUP_PREP,
      SETUP_DIV,
      SETUP_DONE
   } setup_state_type;

   localparam logic [1:0] MODE_PLANAR = 2'd2;

   localparam logic [5:0] SQRT_STEPS = 6'd32;
   localparam logic [5:0] DIV_STEPS  = 6'd63;

   localparam logic signed [33:0] Q30_ONE    = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN  = 34'sd2147483648;
   localparam logic signed [33:0] GAIN_START = 34'sd652032874;

   localparam logic signed [33:0] ATAN_TURNS [32] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
      34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
      34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
      34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
      34'sd652, 34'sd326, 34'sd163, 34'sd81,
      34'sd41, 34'sd20, 34'sd10, 34'sd5,
      34'sd3, 34'sd1, 34'sd1, 34'sd0
   };

   typedef struct packed {
      logic              neg;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   typedef struct packed {
      logic              ready;
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
      logic signed [32:0] omc;
      logic signed [31:0] ux;
      logic signed [31:0] uy;
      logic signed [31:0] uz;
   } setup_out_type;

   typedef logic signed [71:0] wide_type;

   // floor((v + 2^29) / 2^30)
   function automatic wide_type rnd30(wide_type v);
      wide_type t;
      t = v + 72'sd536870912;
      return t >>> 30;
   endfunction

   function automatic logic signed [31:0] sat32(wide_type v);
      logic signed [31:0] r;
      if (v > 72'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -72'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ===== src/prot_cordic_cell.sv =====
// One rotation-mode CORDIC iteration, registered.
// Depends on prot_pkg (cordic_type, arctangent table).
`timescale 1ns / 1ps

module prot_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  prot_pkg::cordic_type cin,
   output prot_pkg::cordic_type cout
);

   always_ff @(posedge clock) begin
      cout.neg <= cin.neg;
      if (cin.z >= 0) begin
         cout.x <= cin.x - (cin.y >>> STAGE);
         cout.y <= cin.y + (cin.x >>> STAGE);
         cout.z <= cin.z - prot_pkg::ATAN_TURNS[STAGE];
      end else begin
         cout.x <= cin.x + (cin.y >>> STAGE);
         cout.y <= cin.y - (cin.x >>> STAGE);
         cout.z <= cin.z + prot_pkg::ATAN_TURNS[STAGE];
      end
   end

endmodule

// ===== src/prot_setup.sv =====
// Config-derived constants: sine/cosine through a chain of CORDIC cells,
// axis norm (bit-serial square root) and unit axis (bit-serial division).
// Depends on prot_pkg and prot_cordic_cell.
`timescale 1ns / 1ps

module prot_setup #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic signed [15:0]      axis_x,
   input  logic signed [15:0]      axis_y,
   input  logic signed [15:0]      axis_z,
   input  logic [15:0]             turn_angle,
   output prot_pkg::setup_out_type setup_out
);

   prot_pkg::setup_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic do_load, do_sqrt, do_prep, do_div;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prot_pkg::SETUP_LOAD: state_in = prot_pkg::SETUP_SQRT;
         prot_pkg::SETUP_SQRT: begin
            if (cnt_ff == prot_pkg::SQRT_STEPS - 6'd1)
               state_in = prot_pkg::SETUP_PREP;
         end
         prot_pkg::SETUP_PREP: state_in = prot_pkg::SETUP_DIV;
         prot_pkg::SETUP_DIV: begin
            if (cnt_ff == prot_pkg::DIV_STEPS - 6'd1)
               state_in = prot_pkg::SETUP_DONE;
         end
         prot_pkg::SETUP_DONE: state_in = prot_pkg::SETUP_DONE;
         default: state_in = prot_pkg::SETUP_LOAD;
      endcase
      if (restart)
         state_in = prot_pkg::SETUP_LOAD;
      cnt_in = (state_in != state_ff) ? 6'd0 : cnt_ff + 6'd1;
   end

   always_comb begin
      do_load = 1'b0;
      do_sqrt = 1'b0;
      do_prep = 1'b0;
      do_div  = 1'b0;
      case (state_ff)
         prot_pkg::SETUP_LOAD: do_load = 1'b1;
         prot_pkg::SETUP_SQRT: do_sqrt = 1'b1;
         prot_pkg::SETUP_PREP: do_prep = 1'b1;
         prot_pkg::SETUP_DIV:  do_div  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prot_pkg::SETUP_LOAD;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------- norm: floor(sqrt(n2 * 2^32)) ----------------
   logic signed [31:0] sqx, sqy, sqz;
   logic [31:0] n2_sum;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] rem_w, trial;

   assign sqx    = axis_x * axis_x;
   assign sqy    = axis_y * axis_y;
   assign sqz    = axis_z * axis_z;
   assign n2_sum = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
   assign rem_w  = {rem_ff, rad_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (do_load) begin
         rad_ff  <= {n2_sum, 32'd0};
         rem_ff  <= 34'd0;
         root_ff <= 32'd0;
      end else if (do_sqrt) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_w >= trial) begin
            rem_ff  <= rem_w[33:0] - trial[33:0];
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_w[33:0];
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   // ---------------- unit axis: (|a| * 2^46 + n/2) / n ----------------
   logic signed [15:0] axis_v [3];
   logic [62:0] num_ff [3];
   logic [62:0] quo_ff [3];
   logic [31:0] drem_ff [3];
   logic        neg_ff [3];
   logic signed [31:0] unit_v [3];

   assign axis_v[0] = axis_x;
   assign axis_v[1] = axis_y;
   assign axis_v[2] = axis_z;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         logic signed [16:0] a_ext;
         logic [16:0]        mag;
         logic [32:0]        dw;
         a_ext = 17'(axis_v[k]);
         mag   = $unsigned(a_ext < 0 ? -a_ext : a_ext);
         dw    = {drem_ff[k], num_ff[k][62]};
         if (do_prep) begin
            num_ff[k]  <= {mag, 46'd0} + 63'(root_ff >> 1);
            quo_ff[k]  <= 63'd0;
            drem_ff[k] <= 32'd0;
            neg_ff[k]  <= axis_v[k][15];
         end else if (do_div) begin
            num_ff[k] <= {num_ff[k][61:0], 1'b0};
            if (dw >= {1'b0, root_ff}) begin
               drem_ff[k] <= 32'(dw - {1'b0, root_ff});
               quo_ff[k]  <= {quo_ff[k][61:0], 1'b1};
            end else begin
               drem_ff[k] <= dw[31:0];
               quo_ff[k]  <= {quo_ff[k][61:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++)
         unit_v[k] = neg_ff[k] ? -$signed(quo_ff[k][31:0]) : $signed(quo_ff[k][31:0]);
   end

   // ---------------- sine / cosine ----------------
   prot_pkg::cordic_type chain [CORDIC_STEPS + 1];
   logic signed [33:0] z_raw;

   assign z_raw = 34'($signed({turn_angle, 16'h0000}));

   // fold into a quarter turn either side; a half-turn shift negates both outputs
   always_comb begin
      chain[0].x   = prot_pkg::GAIN_START;
      chain[0].y   = 34'sd0;
      chain[0].z   = z_raw;
      chain[0].neg = 1'b0;
      if (z_raw > prot_pkg::Q30_ONE) begin
         chain[0].z   = z_raw - prot_pkg::HALF_TURN;
         chain[0].neg = 1'b1;
      end else if (z_raw < -prot_pkg::Q30_ONE) begin
         chain[0].z   = z_raw + prot_pkg::HALF_TURN;
         chain[0].neg = 1'b1;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      prot_cordic_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .cin   (chain[i]),
         .cout  (chain[i + 1])
      );
   end

   logic signed [33:0] cx, sy, cn, sn;
   logic signed [31:0] cos_ff, sin_ff;
   logic signed [32:0] omc_ff;

   always_comb begin
      cx = chain[CORDIC_STEPS].x;
      sy = chain[CORDIC_STEPS].y;
      if (cx > prot_pkg::Q30_ONE)       cx = prot_pkg::Q30_ONE;
      else if (cx < -prot_pkg::Q30_ONE) cx = -prot_pkg::Q30_ONE;
      if (sy > prot_pkg::Q30_ONE)       sy = prot_pkg::Q30_ONE;
      else if (sy < -prot_pkg::Q30_ONE) sy = -prot_pkg::Q30_ONE;
      cn = chain[CORDIC_STEPS].neg ? -cx : cx;
      sn = chain[CORDIC_STEPS].neg ? -sy : sy;
   end

   always_ff @(posedge clock) begin
      cos_ff <= cn[31:0];
      sin_ff <= sn[31:0];
      omc_ff <= 33'(prot_pkg::Q30_ONE - cn);
   end

   assign setup_out.ready   = (state_ff == prot_pkg::SETUP_DONE);
   assign setup_out.cos_val = cos_ff;
   assign setup_out.sin_val = sin_ff;
   assign setup_out.omc     = omc_ff;
   assign setup_out.ux      = unit_v[0];
   assign setup_out.uy      = unit_v[1];
   assign setup_out.uz      = unit_v[2];

endmodule

// ===== src/prot_point_pipe.sv =====
// Five-stage point pipeline applying Rodrigues' formula or a planar rotation.
// Depends on prot_pkg (setup_out_type, rounding and saturation functions).
`timescale 1ns / 1ps

module prot_point_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [31:0]      point_x,
   input  logic signed [31:0]      point_y,
   input  logic signed [31:0]      point_z,
   input  prot_pkg::fault_type     in_fault,
   input  logic                    in_planar,
   input  prot_pkg::setup_out_type su,
   output logic                    out_valid,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y,
   output logic signed [31:0]      out_z,
   output logic [1:0]              out_fault
);

   logic [3:0] vld_ff;
   prot_pkg::fault_type flt_ff [4];
   logic [3:0] pln_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= 4'd0;
         out_valid <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[2:0], in_valid};
         out_valid <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      flt_ff[0] <= in_fault;
      pln_ff[0] <= in_planar;
      for (int k = 1; k < 4; k++) begin
         flt_ff[k] <= flt_ff[k - 1];
         pln_ff[k] <= pln_ff[k - 1];
      end
   end

   // stage A: products of the point with the unit axis, cos and sin
   logic signed [63:0] uxpx_ff, uypy_ff, uzpz_ff;
   logic signed [63:0] uzpy_ff, uypz_ff, uzpx_ff, uxpz_ff, uypx_ff, uxpy_ff;
   logic signed [63:0] pxc_ff, pyc_ff, pzc_ff, pxs_ff, pys_ff;

   always_ff @(posedge clock) begin
      uxpx_ff <= su.ux * point_x;
      uypy_ff <= su.uy * point_y;
      uzpz_ff <= su.uz * point_z;
      uzpy_ff <= su.uz * point_y;
      uypz_ff <= su.uy * point_z;
      uzpx_ff <= su.uz * point_x;
      uxpz_ff <= su.ux * point_z;
      uypx_ff <= su.uy * point_x;
      uxpy_ff <= su.ux * point_y;
      pxc_ff  <= point_x * su.cos_val;
      pyc_ff  <= point_y * su.cos_val;
      pzc_ff  <= point_z * su.cos_val;
      pxs_ff  <= point_x * su.sin_val;
      pys_ff  <= point_y * su.sin_val;
   end

   // stage B: dot product, cross product, p*cos, planar sums
   logic signed [35:0] dot_ff;
   logic signed [34:0] crx_ff, cry_ff, crz_ff;
   logic signed [33:0] pcx_b_ff, pcy_b_ff, pcz_b_ff;
   logic signed [34:0] plx_b_ff, ply_b_ff;

   always_ff @(posedge clock) begin
      logic signed [33:0] d0, d1, d2;
      prot_pkg::wide_type r;
      r  = prot_pkg::rnd30(prot_pkg::wide_type'(uxpx_ff));
      d0 = r[33:0];
      r  = prot_pkg::rnd30(prot_pkg::wide_type'(uypy_ff));
      d1 = r[33:0];
      r  = prot_pkg::rnd30(prot_pkg::wide_type'(uzpz_ff));
      d2 = r[33:0];
      dot_ff <= 36'(d0) + 36'(d1) + 36'(d2);
      r = prot_pkg::rnd30(prot_pkg::wide_type'(uypz_ff) - prot_pkg::wide_type'(uzpy_ff));
      crx_ff <= r[34:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(uzpx_ff) - prot_pkg::wide_type'(uxpz_ff));
      cry_ff <= r[34:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(uxpy_ff) - prot_pkg::wide_type'(uypx_ff));
      crz_ff <= r[34:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(pxc_ff));
      pcx_b_ff <= r[33:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(pyc_ff));
      pcy_b_ff <= r[33:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(pzc_ff));
      pcz_b_ff <= r[33:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(pxc_ff) - prot_pkg::wide_type'(pys_ff));
      plx_b_ff <= r[34:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(pxs_ff) + prot_pkg::wide_type'(pyc_ff));
      ply_b_ff <= r[34:0];
   end

   // stage C: u * dot and cross * sin
   logic signed [67:0] tx_ff, ty_ff, tz_ff;
   logic signed [66:0] csx_ff, csy_ff, csz_ff;
   logic signed [33:0] pcx_c_ff, pcy_c_ff, pcz_c_ff;
   logic signed [34:0] plx_c_ff, ply_c_ff;

   always_ff @(posedge clock) begin
      tx_ff    <= su.ux * dot_ff;
      ty_ff    <= su.uy * dot_ff;
      tz_ff    <= su.uz * dot_ff;
      csx_ff   <= crx_ff * su.sin_val;
      csy_ff   <= cry_ff * su.sin_val;
      csz_ff   <= crz_ff * su.sin_val;
      pcx_c_ff <= pcx_b_ff;
      pcy_c_ff <= pcy_b_ff;
      pcz_c_ff <= pcz_b_ff;
      plx_c_ff <= plx_b_ff;
      ply_c_ff <= ply_b_ff;
   end

   // stage D: round(u * dot) * (1 - cos)
   logic signed [70:0] tmx_ff, tmy_ff, tmz_ff;
   logic signed [36:0] sx_ff, sy_ff, sz_ff;
   logic signed [33:0] pcx_d_ff, pcy_d_ff, pcz_d_ff;
   logic signed [34:0] plx_d_ff, ply_d_ff;

   always_ff @(posedge clock) begin
      prot_pkg::wide_type r;
      logic signed [37:0] trx, try_v, trz;
      r   = prot_pkg::rnd30(prot_pkg::wide_type'(tx_ff));
      trx = r[37:0];
      r   = prot_pkg::rnd30(prot_pkg::wide_type'(ty_ff));
      try_v = r[37:0];
      r   = prot_pkg::rnd30(prot_pkg::wide_type'(tz_ff));
      trz = r[37:0];
      tmx_ff <= trx * su.omc;
      tmy_ff <= try_v * su.omc;
      tmz_ff <= trz * su.omc;
      r = prot_pkg::rnd30(prot_pkg::wide_type'(csx_ff));
      sx_ff <= r[36:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(csy_ff));
      sy_ff <= r[36:0];
      r = prot_pkg::rnd30(prot_pkg::wide_type'(csz_ff));
      sz_ff <= r[36:0];
      pcx_d_ff <= pcx_c_ff;
      pcy_d_ff <= pcy_c_ff;
      pcz_d_ff <= pcz_c_ff;
      plx_d_ff <= plx_c_ff;
      ply_d_ff <= ply_c_ff;
   end

   // stage E: sum, saturate, select by mode and fault
   always_ff @(posedge clock) begin
      prot_pkg::wide_type vx, vy, vz;
      vx = prot_pkg::rnd30(prot_pkg::wide_type'(tmx_ff)) + prot_pkg::wide_type'(sx_ff)
           + prot_pkg::wide_type'(pcx_d_ff);
      vy = prot_pkg::rnd30(prot_pkg::wide_type'(tmy_ff)) + prot_pkg::wide_type'(sy_ff)
           + prot_pkg::wide_type'(pcy_d_ff);
      vz = prot_pkg::rnd30(prot_pkg::wide_type'(tmz_ff)) + prot_pkg::wide_type'(sz_ff)
           + prot_pkg::wide_type'(pcz_d_ff);
      out_fault <= flt_ff[3];
      if (flt_ff[3] != prot_pkg::FAULT_NONE) begin
         out_x <= 32'sd0;
         out_y <= 32'sd0;
         out_z <= 32'sd0;
      end else if (pln_ff[3]) begin
         out_x <= prot_pkg::sat32(prot_pkg::wide_type'(plx_d_ff));
         out_y <= prot_pkg::sat32(prot_pkg::wide_type'(ply_d_ff));
         out_z <= 32'sd0;
      end else begin
         out_x <= prot_pkg::sat32(vx);
         out_y <= prot_pkg::sat32(vy);
         out_z <= prot_pkg::sat32(vz);
      end
   end

endmodule

// ===== src/point_rotate_about_axis.sv =====
// Point rotation about a configured axis (Rodrigues' formula / planar mode).
// Channels: start/busy command input, one result per item on rsp_* marked by
// rsp_valid for one cycle; the receiver cannot hold results off.
// Configuration: csr_valid/csr_ready write channel, csr_index selects the
// register (0 dim_mode, 1 axis_x, 2 axis_y, 3 axis_z, 4 turn_angle);
// csr_ready is always high.
// Busy is high from the edge that restarts setup (the last reset
// edge or a register write) while the setup unit derives the unit axis (load,
// 32-step square root, prep, then a 63-step divider, one bit per cycle) and
// sine/cosine from a row of CORDIC_STEPS cells. Writes are meant to come only
// while no item is in flight.
// Once busy is low, one point is accepted every cycle; the result appears on
// rsp_* once it has passed the five multiply/round stages of the point
// pipeline.
// Reset clears the registers to their defaults (spatial mode, +z axis, zero
// angle) and drops any items in flight.
// Depends on prot_pkg, prot_setup, prot_point_pipe and the defines header.
`timescale 1ns / 1ps
`include "point_rotate_about_axis_defines.svh"

module point_rotate_about_axis #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_rotated_x,
   output logic signed [31:0] rsp_rotated_y,
   output logic signed [31:0] rsp_rotated_z,
   output logic [1:0]         rsp_fault_code,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [1:0]         dim_mode_ff;
   logic signed [15:0] axis_x_ff, axis_y_ff, axis_z_ff;
   logic [15:0]        turn_angle_ff;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_mode_ff   <= 2'd3;
         axis_x_ff     <= 16'sd0;
         axis_y_ff     <= 16'sd0;
         axis_z_ff     <= 16'sd16384;
         turn_angle_ff <= 16'd0;
      end else if (csr_write) begin
         case (csr_index)
            prot_pkg::CSR_DIM_MODE:   dim_mode_ff   <= csr_wdata[1:0];
            prot_pkg::CSR_AXIS_X:     axis_x_ff     <= csr_wdata;
            prot_pkg::CSR_AXIS_Y:     axis_y_ff     <= csr_wdata;
            prot_pkg::CSR_AXIS_Z:     axis_z_ff     <= csr_wdata;
            prot_pkg::CSR_TURN_ANGLE: turn_angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   prot_pkg::setup_out_type su;

   prot_setup #(.CORDIC_STEPS(CORDIC_STEPS)) u_setup (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .axis_x     (axis_x_ff),
      .axis_y     (axis_y_ff),
      .axis_z     (axis_z_ff),
      .turn_angle (turn_angle_ff),
      .setup_out  (su)
   );

   assign busy = !su.ready;

   prot_pkg::fault_type fault;
   logic planar;

   assign planar = (dim_mode_ff == prot_pkg::MODE_PLANAR);

   always_comb begin
      if (axis_x_ff == 16'sd0 && axis_y_ff == 16'sd0 && axis_z_ff == 16'sd0)
         fault = prot_pkg::FAULT_ZERO_AXIS;
      else if (planar && (axis_x_ff != 16'sd0 || axis_y_ff != 16'sd0 || axis_z_ff <= 16'sd0))
         fault = prot_pkg::FAULT_PLANAR_AXIS;
      else
         fault = prot_pkg::FAULT_NONE;
   end

   prot_point_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .in_fault  (fault),
      .in_planar (planar),
      .su        (su),
      .out_valid (rsp_valid),
      .out_x     (rsp_rotated_x),
      .out_y     (rsp_rotated_y),
      .out_z     (rsp_rotated_z),
      .out_fault (rsp_fault_code)
   );

   `PROT_ASSERT_NOW(a_latency, start && !busy, ##5 rsp_valid, "accepted point gave no result")
   `PROT_ASSERT_NOW(a_no_spurious, rsp_valid, $past(start && !busy, 5), "result without a point")
   `PROT_ASSERT_NEXT(a_write_busy, csr_write, busy, "register write did not restart setup")
   `PROT_ASSERT_NOW(a_fault_zero, rsp_valid && rsp_fault_code != prot_pkg::FAULT_NONE, rsp_rotated_x == 32'sd0 && rsp_rotated_y == 32'sd0 && rsp_rotated_z == 32'sd0, "faulted result not zero")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for point_rotate_about_axis: directed table, then random bursts.
// Expected results come from a fixed-point rotation model kept in this file.
// Depends on prot_pkg and the point_rotate_about_axis RTL.
`timescale 1ns / 1ps

module tb;

   localparam int CORDIC_STEPS = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS = 118;
   localparam logic [2:0] CSR_INDEX_SPARE = 3'd5;
   localparam logic [1:0] MODE_SPATIAL = 2'd3;

   typedef logic signed [79:0] acc_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         fault;
   } rotated_point_type;

   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] ax, ay, az;
      logic [15:0]        ang;
      logic signed [31:0] px, py, pz;
      bit                 typed;
      rotated_point_type  want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_point_x, req_point_y, req_point_z;
   logic               rsp_valid;
   logic signed [31:0] rsp_rotated_x, rsp_rotated_y, rsp_rotated_z;
   logic [1:0]         rsp_fault_code;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // mirror of the block's registers
   logic [1:0]         cfg_mode;
   logic signed [15:0] cfg_ax, cfg_ay, cfg_az;
   logic [15:0]        cfg_ang;

   rotated_point_type pending_points[$];
   directed_row_type  directed_rows[$];
   int                error_count = 0;
   int                idle_cycles = 0;

   always #4 clock = ~clock;

   point_rotate_about_axis #(.CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

   function automatic acc_type round_q30(acc_type v);
      return (v + 80'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [31:0] clip32(acc_type v);
      if (v > 80'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (v < -80'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic acc_type clamp_unit(acc_type v);
      if (v > 80'sd1073741824)
         return 80'sd1073741824;
      if (v < -80'sd1073741824)
         return -80'sd1073741824;
      return v;
   endfunction

   // CORDIC sine/cosine in Q2.30 after folding the angle into a quarter turn
   task automatic angle_sincos(input logic [15:0] ang, output acc_type c, output acc_type s);
      acc_type z, x, y, nx;
      bit      neg;
      z = 0;
      z[31:16] = ang;
      x = 80'sd652032874;
      y = 0;
      neg = 1'b0;
      if (z >= 80'sd2147483648)
         z = z - 80'sd4294967296;
      if (z > 80'sd1073741824) begin
         z = z - 80'sd2147483648;
         neg = 1'b1;
      end else if (z < -80'sd1073741824) begin
         z = z + 80'sd2147483648;
         neg = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - acc_type'(prot_pkg::ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + acc_type'(prot_pkg::ATAN_TURNS[i]);
         end
         x = nx;
      end
      x = clamp_unit(x);
      y = clamp_unit(y);
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v)
         b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic acc_type unit_component(logic signed [15:0] a, longint unsigned n);
      longint unsigned mag, q;
      mag = (a < 0) ? longint'(-int'(a)) : longint'(a);
      q = ((mag << 46) + (n >> 1)) / n;
      return (a < 0) ? -acc_type'(q) : acc_type'(q);
   endfunction

   task automatic rotate_point(input logic signed [31:0] x_in, y_in, z_in,
                               output rotated_point_type r);
      acc_type px, py, pz, ax, ay, az, c, s, ux, uy, uz, dot, omc, crx, cry, crz;
      longint unsigned n;
      px = x_in;
      py = y_in;
      pz = z_in;
      ax = cfg_ax;
      ay = cfg_ay;
      az = cfg_az;
      r = '{x: 0, y: 0, z: 0, fault: prot_pkg::FAULT_NONE};
      if (ax == 0 && ay == 0 && az == 0) begin
         r.fault = prot_pkg::FAULT_ZERO_AXIS;
      end else if (cfg_mode == prot_pkg::MODE_PLANAR) begin
         if (ax != 0 || ay != 0 || az <= 0) begin
            r.fault = prot_pkg::FAULT_PLANAR_AXIS;
         end else begin
            angle_sincos(cfg_ang, c, s);
            r.x = clip32(round_q30(px * c - py * s));
            r.y = clip32(round_q30(px * s + py * c));
         end
      end else begin
         n = isqrt(longint'(ax * ax + ay * ay + az * az) << 32);
         ux = unit_component(cfg_ax, n);
         uy = unit_component(cfg_ay, n);
         uz = unit_component(cfg_az, n);
         angle_sincos(cfg_ang, c, s);
         dot = round_q30(ux * px) + round_q30(uy * py) + round_q30(uz * pz);
         omc = 80'sd1073741824 - c;
         crx = round_q30(-uz * py + uy * pz);
         cry = round_q30(uz * px - ux * pz);
         crz = round_q30(-uy * px + ux * py);
         r.x = clip32(round_q30(round_q30(ux * dot) * omc) + round_q30(px * c)
                      + round_q30(crx * s));
         r.y = clip32(round_q30(round_q30(uy * dot) * omc) + round_q30(py * c)
                      + round_q30(cry * s));
         r.z = clip32(round_q30(round_q30(uz * dot) * omc) + round_q30(pz * c)
                      + round_q30(crz * s));
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("%0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      rotated_point_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid) begin
            if (pending_points.size() == 0) begin
               report_mismatch("result with no point outstanding");
            end else begin
               want = pending_points.pop_front();
               if (rsp_rotated_x !== want.x)
                  report_mismatch($sformatf("rotated_x got %h expected %h",
                                            rsp_rotated_x, want.x));
               if (rsp_rotated_y !== want.y)
                  report_mismatch($sformatf("rotated_y got %h expected %h",
                                            rsp_rotated_y, want.y));
               if (rsp_rotated_z !== want.z)
                  report_mismatch($sformatf("rotated_z got %h expected %h",
                                            rsp_rotated_z, want.z));
               if (rsp_fault_code !== want.fault)
                  report_mismatch($sformatf("fault_code got %h expected %h",
                                            rsp_fault_code, want.fault));
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // one point transfer; holds start until the block takes it
   task automatic send_point(logic signed [31:0] x, y, z, bit typed,
                             rotated_point_type given);
      rotated_point_type want;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (typed)
         want = given;
      else
         rotate_point(x, y, z, want);
      pending_points.push_back(want);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_points.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can follow back to back; caller drops it
   task automatic write_csr(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         prot_pkg::CSR_DIM_MODE:   cfg_mode = data[1:0];
         prot_pkg::CSR_AXIS_X:     cfg_ax = data;
         prot_pkg::CSR_AXIS_Y:     cfg_ay = data;
         prot_pkg::CSR_AXIS_Z:     cfg_az = data;
         prot_pkg::CSR_TURN_ANGLE: cfg_ang = data;
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [1:0] mode, logic signed [15:0] ax, ay, az,
                               logic [15:0] ang);
      drain();
      write_csr(prot_pkg::CSR_DIM_MODE, {14'd0, mode});
      write_csr(prot_pkg::CSR_AXIS_X, ax);
      write_csr(prot_pkg::CSR_AXIS_Y, ay);
      write_csr(prot_pkg::CSR_AXIS_Z, az);
      write_csr(prot_pkg::CSR_TURN_ANGLE, ang);
      // writes to unused indexes must leave everything alone
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_INDEX_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(logic [1:0] mode, logic signed [15:0] ax, ay, az,
                                   logic [15:0] ang, logic signed [31:0] px, py, pz,
                                   bit typed = 0,
                                   logic [1:0] fault = prot_pkg::FAULT_NONE);
      directed_row_type row;
      row = '{mode: mode, ax: ax, ay: ay, az: az, ang: ang, px: px, py: py, pz: pz,
              typed: typed, want: '{x: 0, y: 0, z: 0, fault: fault}};
      directed_rows.push_back(row);
   endfunction

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom) >>> $urandom_range(4, 14);
      endcase
   endfunction

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return 16'sd0;
         2: return $signed(16'($urandom)) >>> $urandom_range(8, 14);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [1:0]         mode;
      logic signed [15:0] ax, ay, az;
      int                 burst;
      reset <= 1'b1;
      start <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      csr_valid <= 1'b0;
      csr_index <= prot_pkg::CSR_DIM_MODE;
      csr_wdata <= '0;
      cfg_mode = MODE_SPATIAL;
      cfg_ax = 0;
      cfg_ay = 0;
      cfg_az = 16384;
      cfg_ang = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // a zero point stays at the origin under the reset settings
      add_row(MODE_SPATIAL, 0, 0, 16384, 0, 0, 0, 0, 1);
      add_row(MODE_SPATIAL, 0, 0, 16384, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      add_row(MODE_SPATIAL, 0, 0, 16384, 16'h4000, 32'h0001_0000, 0, 32'h0005_0000);
      add_row(MODE_SPATIAL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h8000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_row(MODE_SPATIAL, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      add_row(MODE_SPATIAL, 16'sh8000, 16'sh7FFF, 1, 16'hC000,
              32'sh8000_0000, 32'sh7FFF_FFFF, -1);
      add_row(MODE_SPATIAL, 0, 0, 0, 16'h1234, 32'h1234_5678, 5, 7, 1,
              prot_pkg::FAULT_ZERO_AXIS);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 0, 16'h1234, 32'sh8000_0000, 5, 7, 1,
              prot_pkg::FAULT_ZERO_AXIS);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 16'sh7FFF, 0, 32'h0001_0000, 32'h0002_0000, 9);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 16'sh7FFF, 16'h4000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 9);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 1, 16'h8000, 32'sh8000_0000, 32'sh8000_0000, -1);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 1, 16'h2000, 32'h0003_0000, -32'sh0001_0000, 3);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 1, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
      add_row(prot_pkg::MODE_PLANAR, 1, 0, 16'sh7FFF, 16'h1000, 5, 6, 7, 1,
              prot_pkg::FAULT_PLANAR_AXIS);
      add_row(prot_pkg::MODE_PLANAR, 0, -1, 16'sh7FFF, 16'h1000, 5, 6, 7, 1,
              prot_pkg::FAULT_PLANAR_AXIS);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, 16'sh8000, 16'h1000, 5, 6, 7, 1,
              prot_pkg::FAULT_PLANAR_AXIS);
      add_row(prot_pkg::MODE_PLANAR, 0, 0, -1, 16'h1000, 5, 6, 7, 1,
              prot_pkg::FAULT_PLANAR_AXIS);
      // unused mode codes act as spatial
      add_row(2'd0, 0, 16'sh4000, 0, 16'h3000, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      add_row(2'd1, 16'sh0100, 0, 0, 16'hD000, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      add_row(2'd1, 0, 16'sh0100, 0, 16'h0001, 0, 0, 0, 1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != cfg_mode || directed_rows[i].ax != cfg_ax
             || directed_rows[i].ay != cfg_ay || directed_rows[i].az != cfg_az
             || directed_rows[i].ang != cfg_ang)
            apply_config(directed_rows[i].mode, directed_rows[i].ax, directed_rows[i].ay,
                         directed_rows[i].az, directed_rows[i].ang);
         send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                    directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // planar about +z, the normal planar use
               mode = prot_pkg::MODE_PLANAR;
               ax = 0;
               ay = 0;
               az = $urandom_range(1, 32767);
            end
            4: begin
               mode = prot_pkg::MODE_PLANAR;
               ax = random_axis();
               ay = random_axis();
               az = random_axis();
            end
            default: begin
               mode = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 1)) : MODE_SPATIAL;
               ax = random_axis();
               ay = random_axis();
               az = random_axis();
               if (ax == 0 && ay == 0 && az == 0 && $urandom_range(0, 3) != 0)
                  az = 16'sd1;
            end
         endcase
         apply_config(mode, ax, ay, az, 16'($urandom));
         burst = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 40);
               if ($urandom_range(0, 2) != 0) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            send_point(random_coord(), random_coord(), random_coord(), 0, '{0, 0, 0, 0});
            burst--;
         end
      end

      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
